// File: src/cmoc_pkg.sv
// Shared types, widths and codes for the midpoint circle octant outline block.
`default_nettype none
package cmoc_pkg;

	localparam int RADIUS_WIDTH = 14;
	localparam int CENTER_W     = 15;
	localparam int COORD_W      = 16;
	localparam int COLOR_W      = 16;
	localparam int MASK_W       = 8;
	localparam int DEC_W        = RADIUS_WIDTH + 4;
	localparam int INC_W        = RADIUS_WIDTH + 3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// octant mask bits that enable each axis pixel of a start
	localparam logic [MASK_W-1:0] AXIS_TOP    = 8'h18;
	localparam logic [MASK_W-1:0] AXIS_BOTTOM = 8'h81;
	localparam logic [MASK_W-1:0] AXIS_RIGHT  = 8'h06;
	localparam logic [MASK_W-1:0] AXIS_LEFT   = 8'h60;

	typedef logic signed [CENTER_W-1:0] center_t;
	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic [RADIUS_WIDTH-1:0]    walk_t;
	typedef logic signed [DEC_W-1:0]    dec_t;
	typedef logic signed [INC_W-1:0]    inc_t;
	typedef logic [COLOR_W-1:0]         color_t;
	typedef logic [MASK_W-1:0]          mask_t;

	// One item's worth of pixel work. Slot k of pend is the pixel
	// (ox +/- u, oy +/- v): slots 4..7 swap a and b, odd slots negate the
	// column offset, slots 2,3,6,7 negate the row offset.
	typedef struct packed {
		center_t origin_x;
		center_t origin_y;
		walk_t   a;
		walk_t   b;
		color_t  color;
		mask_t   pend;
		logic    blank;
		logic    done;
	} job_t;

endpackage
`default_nettype wire

// File: src/cmoc_walker.sv
// Circle walker: holds the midpoint state and builds the pixel job of each item.
`default_nettype none
module cmoc_walker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic                 cmd,
	input  wire cmoc_pkg::center_t    center_x,
	input  wire cmoc_pkg::center_t    center_y,
	input  wire cmoc_pkg::walk_t      radius,
	input  wire cmoc_pkg::mask_t      octant_mask,
	input  wire cmoc_pkg::color_t     pixel_color,
	output cmoc_pkg::job_t            job
);
	import cmoc_pkg::*;

	center_t origin_x_q, origin_y_q;
	walk_t   walk_x_q, walk_y_q;
	dec_t    decision_q;
	inc_t    x_inc_q, y_inc_q;
	mask_t   mask_q;
	color_t  color_q;

	logic    finished;
	logic    dec_pos;
	walk_t   x_n, y_n;
	inc_t    x_inc_n, y_inc_n;
	dec_t    dec_n;
	dec_t    r_dec;

	assign finished = (walk_y_q >= walk_x_q);
	assign dec_pos  = (decision_q > dec_t'(0));
	assign x_n      = dec_pos ? walk_x_q - walk_t'(1) : walk_x_q;
	assign y_n      = walk_y_q + walk_t'(1);
	assign x_inc_n  = dec_pos ? x_inc_q + inc_t'(2) : x_inc_q;
	assign y_inc_n  = y_inc_q + inc_t'(2);
	assign dec_n    = decision_q + (dec_pos ? dec_t'(x_inc_n) : dec_t'(0)) + dec_t'(y_inc_n);
	assign r_dec    = dec_t'(radius);

	always_comb begin
		job = '0;
		if (cmd == CMD_START) begin
			job.origin_x = center_x;
			job.origin_y = center_y;
			job.a        = '0;
			job.b        = radius;
			job.color    = pixel_color;
			job.pend[0]  = |(octant_mask & AXIS_TOP);
			job.pend[2]  = |(octant_mask & AXIS_BOTTOM);
			job.pend[4]  = |(octant_mask & AXIS_RIGHT);
			job.pend[5]  = |(octant_mask & AXIS_LEFT);
			job.done     = (radius == '0);
		end else if (finished) begin
			job.done     = 1'b1;
		end else begin
			job.origin_x = origin_x_q;
			job.origin_y = origin_y_q;
			job.a        = x_n;
			job.b        = y_n;
			job.color    = color_q;
			job.pend     = {mask_q[7], mask_q[0], mask_q[4], mask_q[3],
				mask_q[6], mask_q[1], mask_q[5], mask_q[2]};
			job.done     = (y_n >= x_n);
		end
		job.blank = (job.pend == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			walk_x_q   <= '0;
			walk_y_q   <= '0;
			decision_q <= '0;
			x_inc_q    <= '0;
			y_inc_q    <= inc_t'(1);
			mask_q     <= '0;
			color_q    <= '0;
		end else if (accept) begin
			if (cmd == CMD_START) begin
				origin_x_q <= center_x;
				origin_y_q <= center_y;
				mask_q     <= octant_mask;
				color_q    <= pixel_color;
				walk_x_q   <= radius;
				walk_y_q   <= '0;
				decision_q <= dec_t'(1) - r_dec;
				x_inc_q    <= -(inc_t'(radius) <<< 1);
				y_inc_q    <= inc_t'(1);
			end else if (!finished) begin
				walk_x_q   <= x_n;
				walk_y_q   <= y_n;
				decision_q <= dec_n;
				x_inc_q    <= x_inc_n;
				y_inc_q    <= y_inc_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/cmoc_emitter.sv
// Pixel emitter: job register, slot selection and the result register.
`default_nettype none
module cmoc_emitter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire cmoc_pkg::job_t    job,
	output logic                   job_free,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cmoc_pkg::coord_t       pixel_x,
	output cmoc_pkg::coord_t       pixel_y,
	output cmoc_pkg::color_t       color_out,
	output logic                   pixel_valid,
	output logic                   last,
	output logic                   done_res
);
	import cmoc_pkg::*;

	logic    busy_s1;
	mask_t   pend_s1;
	job_t    job_s1;

	logic    out_free, emit, job_last;
	mask_t   cur_oh;
	logic    swap, neg_x, neg_y;
	coord_t  u, v, px, py;

	assign out_free = !out_valid || out_ready;
	assign emit     = busy_s1 && out_free;
	assign cur_oh   = pend_s1 & (~pend_s1 + mask_t'(1));
	assign job_last = job_s1.blank || ((pend_s1 & ~cur_oh) == '0);
	assign job_free = !busy_s1 || (emit && job_last);

	assign swap  = |cur_oh[7:4];
	assign neg_x = cur_oh[1] | cur_oh[3] | cur_oh[5] | cur_oh[7];
	assign neg_y = cur_oh[2] | cur_oh[3] | cur_oh[6] | cur_oh[7];
	assign u     = swap ? coord_t'(job_s1.b) : coord_t'(job_s1.a);
	assign v     = swap ? coord_t'(job_s1.a) : coord_t'(job_s1.b);
	assign px    = coord_t'(job_s1.origin_x) + (neg_x ? -u : u);
	assign py    = coord_t'(job_s1.origin_y) + (neg_y ? -v : v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			pend_s1 <= '0;
		end else if (load) begin
			busy_s1 <= 1'b1;
			pend_s1 <= job.pend;
		end else if (emit) begin
			pend_s1 <= pend_s1 & ~cur_oh;
			if (job_last) begin
				busy_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// an empty item gives one result with zero payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x     <= job_s1.blank ? '0 : px;
			pixel_y     <= job_s1.blank ? '0 : py;
			color_out   <= job_s1.blank ? '0 : job_s1.color;
			pixel_valid <= !job_s1.blank;
			last        <= job_last;
			done_res    <= job_s1.done;
		end
	end

endmodule
`default_nettype wire

// File: src/midpoint_circle_octant_outline_top.sv
// Top level of the midpoint circle octant outline generator.
// A start item (cmd 0) latches centre, radius, octant mask and colour and
// gives the axis pixels that the mask enables; each step item (cmd 1) runs one
// midpoint iteration and gives the pixels of the enabled octants, or one blank
// result once the walk is finished. Results leave one per cycle while out_ready is
// high, from a single result register, so an item gives max(1, enabled pixels)
// results, at most 8 for a step and 4 for a start; an item that gives no pixel
// yields one result with pixel_valid low. The circle state updates when the item is
// accepted, and the next item is taken in the cycle that the previous item's final
// pixel moves into the result register, so with out_ready high items flow back to back.
`default_nettype none
module midpoint_circle_octant_outline_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cmd,
	input  wire cmoc_pkg::center_t center_x,
	input  wire cmoc_pkg::center_t center_y,
	input  wire cmoc_pkg::walk_t   radius,
	input  wire cmoc_pkg::mask_t   octant_mask,
	input  wire cmoc_pkg::color_t  pixel_color,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output cmoc_pkg::coord_t       pixel_x,
	output cmoc_pkg::coord_t       pixel_y,
	output cmoc_pkg::color_t       color_out,
	output logic                   pixel_valid,
	output logic                   last,
	output logic                   done_res
);
	import cmoc_pkg::*;

	logic accept;
	job_t job;

	assign accept = in_valid && in_ready;

	cmoc_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.octant_mask (octant_mask),
		.pixel_color (pixel_color),
		.job         (job)
	);

	cmoc_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.job         (job),
		.job_free    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color_out   (color_out),
		.pixel_valid (pixel_valid),
		.last        (last),
		.done_res    (done_res)
	);

	a_blank_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> last)
		else $error("empty result not marked last");

	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && color_out == '0)
		else $error("empty result carries payload");

	a_item_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("item results broken off before last");

	a_no_take_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_ready |-> !in_ready)
		else $error("new item taken while pixels of an item remain");

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the midpoint circle octant outline generator.
`default_nettype none
module tb;
	import cmoc_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_TICKS = 5;
	localparam int DIR_ROWS    = 25;
	localparam int RAND_ITEMS  = 195;
	localparam int MAX_GAP     = 16;
	localparam int TAIL_CYCLES = 32;
	localparam int DRAIN_EVERY = 70;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic    cmd;
		center_t cx;
		center_t cy;
		walk_t   r;
		mask_t   m;
		color_t  col;
	} stim_t;

	typedef struct packed {
		coord_t px;
		coord_t py;
		color_t col;
		logic   pv;
		logic   lst;
		logic   dn;
	} pixel_res_t;

	typedef struct packed {
		stim_t      st;
		logic       typed;
		pixel_res_t want;
	} dir_row_t;

	localparam pixel_res_t NO_WANT = '0;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	logic    cmd;
	center_t center_x;
	center_t center_y;
	walk_t   radius;
	mask_t   octant_mask;
	color_t  pixel_color;
	logic    out_valid;
	logic    out_ready;
	coord_t  pixel_x;
	coord_t  pixel_y;
	color_t  color_out;
	logic    pixel_valid;
	logic    last;
	logic    done_res;

	midpoint_circle_octant_outline_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.octant_mask(octant_mask),
		.pixel_color(pixel_color),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.color_out  (color_out),
		.pixel_valid(pixel_valid),
		.last       (last),
		.done_res   (done_res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predicted circle state
	center_t ctr_x, ctr_y;
	walk_t   wx, wy;
	dec_t    dec;
	inc_t    x_step, y_step;
	mask_t   msk;
	color_t  col_l;

	pixel_res_t pixels_due[$];
	pixel_res_t fresh[$];
	dir_row_t   dtab [DIR_ROWS];

	int  fails;
	int  items_sent;
	int  n_starts;
	int  n_steps;
	int  results_seen;
	int  pixels_seen;
	int  circles_done;
	logic send_calm;
	logic recv_calm;

	function automatic pixel_res_t plot(int x, int y);
		pixel_res_t p;
		p = '0;
		p.px = coord_t'(x);
		p.py = coord_t'(y);
		p.col = col_l;
		p.pv = 1'b1;
		return p;
	endfunction

	function automatic dir_row_t row(logic c, int cx, int cy, int r, int m, int col,
			logic typed, pixel_res_t w);
		dir_row_t d;
		d.st.cmd = c;
		d.st.cx = center_t'(cx);
		d.st.cy = center_t'(cy);
		d.st.r = walk_t'(r);
		d.st.m = mask_t'(m);
		d.st.col = color_t'(col);
		d.typed = typed;
		d.want = w;
		return d;
	endfunction

	function automatic pixel_res_t one(int x, int y, int col, logic pv, logic dn);
		pixel_res_t p;
		p.px = coord_t'(x);
		p.py = coord_t'(y);
		p.col = color_t'(col);
		p.pv = pv;
		p.lst = 1'b1;
		p.dn = dn;
		return p;
	endfunction

	function automatic stim_t random_item(logic c);
		stim_t s;
		s.cmd = c;
		s.cx = center_t'($urandom);
		s.cy = center_t'($urandom);
		s.r = walk_t'($urandom);
		s.m = mask_t'($urandom);
		s.col = color_t'($urandom);
		return s;
	endfunction

	// Work out the pixels that one item gives and advance the circle state.
	task automatic trace_circle(input stim_t s);
		int ox, oy, x, y;
		logic fin;
		fresh.delete();
		if (s.cmd == CMD_START) begin
			ctr_x = s.cx;
			ctr_y = s.cy;
			msk = s.m;
			col_l = s.col;
			wx = s.r;
			wy = '0;
			dec = dec_t'(1 - int'(s.r));
			x_step = inc_t'(-2 * int'(s.r));
			y_step = inc_t'(1);
			ox = ctr_x;
			oy = ctr_y;
			x = int'(wx);
			if ((msk & AXIS_TOP) != '0) fresh.push_back(plot(ox, oy + x));
			if ((msk & AXIS_BOTTOM) != '0) fresh.push_back(plot(ox, oy - x));
			if ((msk & AXIS_RIGHT) != '0) fresh.push_back(plot(ox + x, oy));
			if ((msk & AXIS_LEFT) != '0) fresh.push_back(plot(ox - x, oy));
		end else if (wy < wx) begin
			if (dec > 0) begin
				wx = wx - 1'b1;
				x_step = x_step + inc_t'(2);
				dec = dec + dec_t'(x_step);
			end
			wy = wy + 1'b1;
			y_step = y_step + inc_t'(2);
			dec = dec + dec_t'(y_step);
			ox = ctr_x;
			oy = ctr_y;
			x = int'(wx);
			y = int'(wy);
			if (msk[2]) fresh.push_back(plot(ox + x, oy + y));
			if (msk[5]) fresh.push_back(plot(ox - x, oy + y));
			if (msk[1]) fresh.push_back(plot(ox + x, oy - y));
			if (msk[6]) fresh.push_back(plot(ox - x, oy - y));
			if (msk[3]) fresh.push_back(plot(ox + y, oy + x));
			if (msk[4]) fresh.push_back(plot(ox - y, oy + x));
			if (msk[0]) fresh.push_back(plot(ox + y, oy - x));
			if (msk[7]) fresh.push_back(plot(ox - y, oy - x));
		end
		// an item with no pixel still gives one blank result
		if (fresh.size() == 0) fresh.push_back(NO_WANT);
		fin = (wy >= wx);
		foreach (fresh[i]) fresh[i].dn = fin;
		fresh[fresh.size() - 1].lst = 1'b1;
	endtask

	task automatic drive_item(input stim_t s, input logic typed, input pixel_res_t want);
		int gap;
		logic was_done;
		gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= s.cmd;
		center_x <= s.cx;
		center_y <= s.cy;
		radius <= s.r;
		octant_mask <= s.m;
		pixel_color <= s.col;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		was_done = (wy >= wx);
		trace_circle(s);
		if (typed) begin
			pixels_due.push_back(want);
		end else begin
			foreach (fresh[i]) pixels_due.push_back(fresh[i]);
		end
		items_sent++;
		if (s.cmd == CMD_START) begin
			n_starts++;
		end else begin
			n_steps++;
			if (!was_done && wy >= wx) circles_done++;
		end
		if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
	endtask

	// hold the sender off until every outstanding pixel has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
	endtask

	task automatic check_pixel();
		pixel_res_t got, want;
		logic bad;
		got.px = pixel_x;
		got.py = pixel_y;
		got.col = color_out;
		got.pv = pixel_valid;
		got.lst = last;
		got.dn = done_res;
		results_seen++;
		if (pixel_valid === 1'b1) pixels_seen++;
		if (pixels_due.size() == 0) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("ERROR: unexpected result x=%0d y=%0d col=%h pv=%b last=%b done=%b",
					got.px, got.py, got.col, got.pv, got.lst, got.dn);
			return;
		end
		want = pixels_due.pop_front();
		bad = (got.px !== want.px) || (got.py !== want.py) || (got.col !== want.col)
			|| (got.pv !== want.pv) || (got.lst !== want.lst) || (got.dn !== want.dn);
		if (bad) begin
			fails++;
			if (fails <= MAX_REPORTS) begin
				$display("ERROR: result %0d expected x=%0d y=%0d col=%h pv=%b last=%b done=%b",
					results_seen, want.px, want.py, want.col, want.pv, want.lst, want.dn);
				$display("       got                x=%0d y=%0d col=%h pv=%b last=%b done=%b",
					got.px, got.py, got.col, got.pv, got.lst, got.dn);
			end
		end
	endtask

	// result side: random stalls per result, with calm stretches
	initial begin
		int gap;
		out_ready = 1'b0;
		recv_calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			check_pixel();
			if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
		end
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		stim_t s;
		int k, cap, steps, next_drain;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_START;
		center_x = '0;
		center_y = '0;
		radius = '0;
		octant_mask = '0;
		pixel_color = '0;
		send_calm = 1'b0;
		fails = 0;
		items_sent = 0;
		n_starts = 0;
		n_steps = 0;
		results_seen = 0;
		pixels_seen = 0;
		circles_done = 0;
		ctr_x = '0;
		ctr_y = '0;
		wx = '0;
		wy = '0;
		dec = '0;
		x_step = '0;
		y_step = inc_t'(1);
		msk = '0;
		col_l = '0;

		// step before any start, then axis extremes, zero radius, full circles
		dtab[0]  = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b1, one(0, 0, 0, 1'b0, 1'b1));
		dtab[1]  = row(CMD_START, -16384, 16383, 0, 'h18, 'hFFFF, 1'b1,
			one(-16384, 16383, 'hFFFF, 1'b1, 1'b1));
		dtab[2]  = row(CMD_START, 16383, -16384, 16383, 'h00, 0, 1'b1,
			one(0, 0, 0, 1'b0, 1'b0));
		dtab[3]  = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b1, one(0, 0, 0, 1'b0, 1'b0));
		dtab[4]  = row(CMD_START, 16383, 0, 16383, 'h04, 'h1234, 1'b1,
			one(32766, 0, 'h1234, 1'b1, 1'b0));
		dtab[5]  = row(CMD_START, -16384, -1, 16383, 'h20, 'h8000, 1'b1,
			one(-32767, -1, 'h8000, 1'b1, 1'b0));
		dtab[6]  = row(CMD_START, 0, -16384, 16383, 'h80, 'h00FF, 1'b1,
			one(0, -32767, 'h00FF, 1'b1, 1'b0));
		dtab[7]  = row(CMD_START, 1, 16383, 16383, 'h08, 'h5A5A, 1'b1,
			one(1, 32766, 'h5A5A, 1'b1, 1'b0));
		dtab[8]  = row(CMD_START, -7, 9, 0, 'hFF, 'hC0DE, 1'b0, NO_WANT);
		dtab[9]  = row(CMD_STEP, 3, 3, 3, 3, 3, 1'b1, one(0, 0, 0, 1'b0, 1'b1));
		dtab[10] = row(CMD_START, 100, -50, 5, 'hFF, 'hABCD, 1'b0, NO_WANT);
		dtab[11] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[12] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[13] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[14] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[15] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[16] = row(CMD_START, -3, 4, 3, 'h55, 'h0F0F, 1'b0, NO_WANT);
		dtab[17] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[18] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[19] = row(CMD_START, 20, 20, 3, 'hAA, 'hF0F0, 1'b0, NO_WANT);
		dtab[20] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[21] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[22] = row(CMD_START, -16384, -16384, 16383, 'hFF, 'h7FFF, 1'b0, NO_WANT);
		dtab[23] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);
		dtab[24] = row(CMD_STEP, 0, 0, 0, 0, 0, 1'b0, NO_WANT);

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++) drive_item(dtab[k].st, dtab[k].typed, dtab[k].want);
		drain_results();

		// random part: mostly whole circles, some cut short, some noise
		next_drain = DIR_ROWS + DRAIN_EVERY;
		while (items_sent < DIR_ROWS + RAND_ITEMS) begin
			if (items_sent >= next_drain) begin
				drain_results();
				next_drain += DRAIN_EVERY;
			end
			if ($urandom_range(0, 9) == 0) begin
				drive_item(random_item(logic'($urandom_range(0, 1))), 1'b0, NO_WANT);
			end else begin
				s = random_item(CMD_START);
				k = $urandom_range(0, 19);
				if (k < 16) s.r = walk_t'($urandom_range(0, 24));
				else if (k < 19) s.r = walk_t'($urandom_range(25, 400));
				if ($urandom_range(0, 3) == 0) s.m = mask_t'(8'hFF);
				drive_item(s, 1'b0, NO_WANT);
				cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 60;
				steps = 0;
				while (wy < wx && steps < cap && items_sent < DIR_ROWS + RAND_ITEMS) begin
					drive_item(random_item(CMD_STEP), 1'b0, NO_WANT);
					steps++;
				end
				if (wy >= wx)
					repeat ($urandom_range(0, 2))
						drive_item(random_item(CMD_STEP), 1'b0, NO_WANT);
			end
		end
		in_valid <= 1'b0;

		while (pixels_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d starts, %0d steps), %0d circles walked to the end.",
			items_sent, n_starts, n_steps, circles_done);
		$display("Checked %0d results, %0d of them pixels, %0d mismatches.",
			results_seen, pixels_seen, fails);
		if (fails == 0 && pixels_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
src/cmoc_pkg.sv
src/cmoc_walker.sv
src/cmoc_emitter.sv
src/midpoint_circle_octant_outline_top.sv
tb/tb.sv
